### sv/cpor_pkg.sv
// Package for the circle pair overlap resolver: request and result types,
// widths of the arithmetic units and the small id reduction helpers.
// No dependencies.
package cpor_pkg;

    localparam int POS_W         = 24;
    localparam int ID_W          = 16;
    localparam int RAD_W         = 16;
    localparam int POS_FRAC_BITS = 8;
    localparam logic [RAD_W-1:0] RAD_RESET = 16'd2560;

    // Centres count as apart when d2 * 10^8 exceeds 2^(2*frac bits).
    localparam longint APART_MIN = (64'd1 << (2 * POS_FRAC_BITS)) / 64'd100000000;

    // Square root unit: 50-bit radicand, one root bit per stage.
    localparam int SQ_IN_W   = 50;
    localparam int SQ_OUT_W  = 25;
    localparam int SQ_STAGES = SQ_OUT_W;

    // Divider unit: one quotient bit per stage.
    localparam int DIV_NUM_W  = 44;
    localparam int DIV_DEN_W  = 28;
    localparam int DIV_Q_W    = 28;
    localparam int DIV_STAGES = DIV_Q_W;

    // Pipeline bookkeeping, counted from the decision stage.
    localparam int TAP_MAG = SQ_STAGES + 1;
    localparam int SB_LEN  = SQ_STAGES + 2 + DIV_STAGES + 1;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_NORMAL = 2'd1,
        KIND_PUSH   = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic [ID_W-1:0]         first_id;
        logic [ID_W-1:0]         second_id;
    } request_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_first_x;
        logic signed [POS_W-1:0] new_first_y;
        logic signed [POS_W-1:0] new_second_x;
        logic signed [POS_W-1:0] new_second_y;
        logic [1:0]              resolution_kind;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0] x1;
        logic [POS_W-1:0] y1;
        logic [POS_W-1:0] x2;
        logic [POS_W-1:0] y2;
        kind_t            kind;
        logic             neg_x;
        logic             neg_y;
        logic [16:0]      mag_x;
        logic [16:0]      mag_y;
    } sideband_t;

    // Since 8 = 1 mod 7, summing 3-bit digits keeps the residue.
    function automatic logic [2:0] mod7(input logic [ID_W-1:0] v);
        logic [5:0] s;
        logic [3:0] t;
        s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
            + 6'(v[15]);
        t = 4'(s[5:3]) + 4'(s[2:0]);
        if (t >= 4'd7)
        begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

    // Since 16 = 1 mod 5, summing nibbles keeps the residue.
    function automatic logic [2:0] mod5(input logic [ID_W-1:0] v);
        logic [5:0] s;
        logic [4:0] t;
        s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
        t = 5'(s[5:4]) + 5'(s[3:0]);
        if (t >= 5'd15)
        begin
            t = t - 5'd15;
        end
        else if (t >= 5'd10)
        begin
            t = t - 5'd10;
        end
        else if (t >= 5'd5)
        begin
            t = t - 5'd5;
        end
        return t[2:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [29:0] v);
        logic [POS_W-1:0] r;
        if (v > 30'sd8388607)
        begin
            r = 24'h7FFFFF;
        end
        else if (v < -30'sd8388608)
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/circle_pair_overlap_resolver_unit.sv
// Top level of the circle pair overlap resolver: decision stages, square root
// and divider pipelines, and the output register. Uses cpor_pkg, cpor_sqrt, cpor_div.
//
//  channel   handshake            payload
//  request   start / busy         request (request_t)
//  result    done (one cycle)     result (result_t)
//  config    cfg_wr_en            cfg_wr_data (circle_radius)
//
// One request is taken every cycle; busy stays low. Four decision stages, the
// 25-stage square root, two multiply stages, the 28-stage divider and the output
// register make 60 register stages in series, the first of which loads at the
// accepting edge.
// Reset clears the valid bits and loads the radius with 10.0.
// The receiver cannot stall, so the pipeline advances on every clock.
module circle_pair_overlap_resolver_unit
    import cpor_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  request_t         request,
    output logic             done,
    output result_t          result,
    input  logic             cfg_wr_en,
    input  logic [RAD_W-1:0] cfg_wr_data
);

    logic [RAD_W-1:0] radius_reg;
    logic             s0_valid_reg;
    request_t         s0_req_reg;

    // stage 1
    logic             s1_valid_reg;
    logic [POS_W-1:0] s1_x1_reg, s1_y1_reg, s1_x2_reg, s1_y2_reg;
    logic [24:0]      s1_magx_reg, s1_magy_reg;
    logic             s1_negx_reg, s1_negy_reg, s1_same_reg;
    logic [1:0]       s1_amag_reg, s1_bmag_reg;
    logic             s1_aneg_reg, s1_bneg_reg;
    logic [24:0]      dx_next, dy_next;
    logic [2:0]       m7_next, m5_next;
    logic [1:0]       amag_next, bmag_next;
    logic             aneg_next, bneg_next;

    // stage 2
    logic             s2_valid_reg;
    logic [POS_W-1:0] s2_x1_reg, s2_y1_reg, s2_x2_reg, s2_y2_reg;
    logic [49:0]      s2_sqx_reg, s2_sqy_reg;
    logic [33:0]      s2_dia2_reg;
    logic [31:0]      s2_r2_reg;
    logic [3:0]       s2_ka2_reg, s2_kb2_reg;
    logic [8:0]       s2_n25_reg;
    logic [16:0]      s2_magx_reg, s2_magy_reg;
    logic             s2_negx_reg, s2_negy_reg, s2_same_reg, s2_aneg_reg, s2_bneg_reg;
    logic [16:0]      dia_next;
    logic [3:0]       ka2_next, kb2_next, n_next;

    // stage 3 and the sideband line that follows it
    sideband_t        sb_reg [SB_LEN];
    logic             sbv_reg [SB_LEN];
    sideband_t        sb0_next;
    logic [49:0]      d2_next;
    logic [33:0]      s3_d2_reg;
    logic [35:0]      s3_pnumx_reg, s3_pnumy_reg;
    logic [8:0]       s3_pden_reg;

    // overlap path
    logic [SQ_OUT_W-1:0]  main_root;
    logic [24:0]          m1_ov_reg;
    logic [26:0]          m1_den_reg;
    logic [41:0]          m2_prodx_reg, m2_prody_reg;
    logic [26:0]          m2_den_reg;
    logic [DIV_Q_W-1:0]   main_qx, main_qy;

    // push path
    logic [DIV_Q_W-1:0]   push_qx, push_qy;
    logic [SQ_OUT_W-1:0]  push_rootx, push_rooty;
    logic [14:0]          pushx_sum, pushy_sum;
    logic [13:0]          p1_x_reg, p1_y_reg, p2_x_reg, p2_y_reg;

    // output
    logic                 done_reg;
    result_t              result_reg;
    result_t              result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            for (int i = 0; i < SB_LEN; i++)
            begin
                sbv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s0_valid_reg <= start & ~busy;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            sbv_reg[0]   <= s2_valid_reg;
            for (int i = 1; i < SB_LEN; i++)
            begin
                sbv_reg[i] <= sbv_reg[i-1];
            end
            done_reg <= sbv_reg[SB_LEN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            s0_req_reg <= request;
        end
    end

    // Stage 1: differences, magnitudes and the push direction from the ids.
    always_comb
    begin
        dx_next = {s0_req_reg.first_x[POS_W-1], s0_req_reg.first_x}
                - {s0_req_reg.second_x[POS_W-1], s0_req_reg.second_x};
        dy_next = {s0_req_reg.first_y[POS_W-1], s0_req_reg.first_y}
                - {s0_req_reg.second_y[POS_W-1], s0_req_reg.second_y};
        m7_next = mod7(s0_req_reg.first_id);
        m5_next = mod5(s0_req_reg.second_id);
        aneg_next = (m7_next < 3'd3);
        bneg_next = (m5_next < 3'd2);
        amag_next = aneg_next ? 2'(3'd3 - m7_next) : 2'(m7_next - 3'd3);
        bmag_next = bneg_next ? 2'(3'd2 - m5_next) : 2'(m5_next - 3'd2);
        // A zero direction falls back to the diagonal.
        if (amag_next == 2'd0 && bmag_next == 2'd0)
        begin
            amag_next = 2'd1;
            bmag_next = 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x1_reg   <= s0_req_reg.first_x;
        s1_y1_reg   <= s0_req_reg.first_y;
        s1_x2_reg   <= s0_req_reg.second_x;
        s1_y2_reg   <= s0_req_reg.second_y;
        s1_magx_reg <= dx_next[24] ? (~dx_next + 25'd1) : dx_next;
        s1_magy_reg <= dy_next[24] ? (~dy_next + 25'd1) : dy_next;
        s1_negx_reg <= dx_next[24];
        s1_negy_reg <= dy_next[24];
        s1_same_reg <= (s0_req_reg.first_id == s0_req_reg.second_id);
        s1_amag_reg <= amag_next;
        s1_bmag_reg <= bmag_next;
        s1_aneg_reg <= aneg_next;
        s1_bneg_reg <= bneg_next;
    end

    // Stage 2: squares.
    always_comb
    begin
        dia_next = {radius_reg, 1'b0};
        ka2_next = {2'b00, s1_amag_reg} * {2'b00, s1_amag_reg};
        kb2_next = {2'b00, s1_bmag_reg} * {2'b00, s1_bmag_reg};
        n_next   = ka2_next + kb2_next;
    end

    always_ff @(posedge clk)
    begin
        s2_x1_reg   <= s1_x1_reg;
        s2_y1_reg   <= s1_y1_reg;
        s2_x2_reg   <= s1_x2_reg;
        s2_y2_reg   <= s1_y2_reg;
        s2_sqx_reg  <= {25'd0, s1_magx_reg} * {25'd0, s1_magx_reg};
        s2_sqy_reg  <= {25'd0, s1_magy_reg} * {25'd0, s1_magy_reg};
        s2_dia2_reg <= {17'd0, dia_next} * {17'd0, dia_next};
        s2_r2_reg   <= {16'd0, radius_reg} * {16'd0, radius_reg};
        s2_ka2_reg  <= ka2_next;
        s2_kb2_reg  <= kb2_next;
        s2_n25_reg  <= {5'd0, n_next} * 9'd25;
        s2_magx_reg <= s1_magx_reg[16:0];
        s2_magy_reg <= s1_magy_reg[16:0];
        s2_negx_reg <= s1_negx_reg;
        s2_negy_reg <= s1_negy_reg;
        s2_same_reg <= s1_same_reg;
        s2_aneg_reg <= s1_aneg_reg;
        s2_bneg_reg <= s1_bneg_reg;
    end

    // Stage 3: classify the pair.
    always_comb
    begin
        logic overlap;
        logic apart;
        d2_next = s2_sqx_reg + s2_sqy_reg;
        overlap = !s2_same_reg && (d2_next < {16'd0, s2_dia2_reg});
        apart   = (d2_next > 50'(APART_MIN));
        sb0_next.x1    = s2_x1_reg;
        sb0_next.y1    = s2_y1_reg;
        sb0_next.x2    = s2_x2_reg;
        sb0_next.y2    = s2_y2_reg;
        sb0_next.mag_x = s2_magx_reg;
        sb0_next.mag_y = s2_magy_reg;
        if (!overlap)
        begin
            sb0_next.kind  = KIND_NONE;
            sb0_next.neg_x = s2_negx_reg;
            sb0_next.neg_y = s2_negy_reg;
        end
        else if (apart)
        begin
            sb0_next.kind  = KIND_NORMAL;
            sb0_next.neg_x = s2_negx_reg;
            sb0_next.neg_y = s2_negy_reg;
        end
        else
        begin
            sb0_next.kind  = KIND_PUSH;
            sb0_next.neg_x = s2_aneg_reg;
            sb0_next.neg_y = s2_bneg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg[0]    <= sb0_next;
        for (int i = 1; i < SB_LEN; i++)
        begin
            sb_reg[i] <= sb_reg[i-1];
        end
        s3_d2_reg    <= d2_next[33:0];
        s3_pnumx_reg <= {32'd0, s2_ka2_reg} * {4'd0, s2_r2_reg};
        s3_pnumy_reg <= {32'd0, s2_kb2_reg} * {4'd0, s2_r2_reg};
        s3_pden_reg  <= s2_n25_reg;
    end

    // Overlap path: distance with 8 extra fraction bits, then the correction.
    cpor_sqrt u_main_sqrt
    (
        .clk      (clk),
        .radicand ({s3_d2_reg, 16'd0}),
        .root     (main_root)
    );

    always_ff @(posedge clk)
    begin
        m1_ov_reg    <= {radius_reg, 9'd0} - main_root;
        m1_den_reg   <= {main_root, 2'b00};
        m2_prodx_reg <= {25'd0, sb_reg[TAP_MAG].mag_x} * {17'd0, m1_ov_reg};
        m2_prody_reg <= {25'd0, sb_reg[TAP_MAG].mag_y} * {17'd0, m1_ov_reg};
        m2_den_reg   <= m1_den_reg;
    end

    // Adding half the divisor rounds the quotient to nearest.
    cpor_div u_main_div_x
    (
        .clk   (clk),
        .numer ({2'b00, m2_prodx_reg} + {18'd0, m2_den_reg[26:1]}),
        .denom ({1'b0, m2_den_reg}),
        .quot  (main_qx)
    );

    cpor_div u_main_div_y
    (
        .clk   (clk),
        .numer ({2'b00, m2_prody_reg} + {18'd0, m2_den_reg[26:1]}),
        .denom ({1'b0, m2_den_reg}),
        .quot  (main_qy)
    );

    // Push path: floor(k^2 r^2 / 25n), then its root is twice the push.
    cpor_div u_push_div_x
    (
        .clk   (clk),
        .numer ({8'd0, s3_pnumx_reg}),
        .denom ({19'd0, s3_pden_reg}),
        .quot  (push_qx)
    );

    cpor_div u_push_div_y
    (
        .clk   (clk),
        .numer ({8'd0, s3_pnumy_reg}),
        .denom ({19'd0, s3_pden_reg}),
        .quot  (push_qy)
    );

    cpor_sqrt u_push_sqrt_x
    (
        .clk      (clk),
        .radicand ({22'd0, push_qx}),
        .root     (push_rootx)
    );

    cpor_sqrt u_push_sqrt_y
    (
        .clk      (clk),
        .radicand ({22'd0, push_qy}),
        .root     (push_rooty)
    );

    assign pushx_sum = {1'b0, push_rootx[13:0]} + 15'd1;
    assign pushy_sum = {1'b0, push_rooty[13:0]} + 15'd1;

    always_ff @(posedge clk)
    begin
        p1_x_reg <= pushx_sum[14:1];
        p1_y_reg <= pushy_sum[14:1];
        p2_x_reg <= p1_x_reg;
        p2_y_reg <= p1_y_reg;
    end

    // Final stage: apply the signed correction and saturate.
    always_comb
    begin
        logic [DIV_Q_W-1:0] mx;
        logic [DIV_Q_W-1:0] my;
        logic signed [29:0] dlx;
        logic signed [29:0] dly;
        sideband_t          sb;
        sb = sb_reg[SB_LEN-1];
        case (sb.kind)
            KIND_NORMAL:
            begin
                mx = main_qx;
                my = main_qy;
            end
            KIND_PUSH:
            begin
                mx = DIV_Q_W'(p2_x_reg);
                my = DIV_Q_W'(p2_y_reg);
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
        dlx = sb.neg_x ? -$signed({2'b00, mx}) : $signed({2'b00, mx});
        dly = sb.neg_y ? -$signed({2'b00, my}) : $signed({2'b00, my});
        result_next.new_first_x  = sat_pos($signed({{6{sb.x1[POS_W-1]}}, sb.x1}) + dlx);
        result_next.new_first_y  = sat_pos($signed({{6{sb.y1[POS_W-1]}}, sb.y1}) + dly);
        result_next.new_second_x = sat_pos($signed({{6{sb.x2[POS_W-1]}}, sb.x2}) - dlx);
        result_next.new_second_y = sat_pos($signed({{6{sb.y2[POS_W-1]}}, sb.y2}) - dly);
        result_next.resolution_kind = sb.kind;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sv/cpor_sqrt.sv
// Pipelined integer square root, floor(sqrt(radicand)), one root bit per stage.
// Depends on cpor_pkg for the unit widths.
module cpor_sqrt
    import cpor_pkg::*;
(
    input  logic                clk,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic [SQ_OUT_W-1:0] root
);

    logic [SQ_IN_W-1:0]  rad_reg  [SQ_STAGES];
    logic [SQ_OUT_W+1:0] rem_reg  [SQ_STAGES];
    logic [SQ_OUT_W-1:0] root_reg [SQ_STAGES];
    logic [SQ_IN_W-1:0]  rad_next  [SQ_STAGES];
    logic [SQ_OUT_W+1:0] rem_next  [SQ_STAGES];
    logic [SQ_OUT_W-1:0] root_next [SQ_STAGES];

    always_comb
    begin
        logic [SQ_IN_W-1:0]  rad_cur;
        logic [SQ_OUT_W+1:0] rem_cur;
        logic [SQ_OUT_W-1:0] root_cur;
        logic [SQ_OUT_W+3:0] rem_sh;
        logic [SQ_OUT_W+3:0] trial;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            if (k == 0)
            begin
                rad_cur  = radicand;
                rem_cur  = '0;
                root_cur = '0;
            end
            else
            begin
                rad_cur  = rad_reg[k-1];
                rem_cur  = rem_reg[k-1];
                root_cur = root_reg[k-1];
            end
            rem_sh = {rem_cur, rad_cur[SQ_IN_W-1:SQ_IN_W-2]};
            trial  = {2'b00, root_cur, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next[k]  = (SQ_OUT_W+2)'(rem_sh - trial);
                root_next[k] = {root_cur[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh[SQ_OUT_W+1:0];
                root_next[k] = {root_cur[SQ_OUT_W-2:0], 1'b0};
            end
            rad_next[k] = {rad_cur[SQ_IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            rad_reg[k]  <= rad_next[k];
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

### sv/cpor_div.sv
// Pipelined restoring divider, floor(numer / denom), one quotient bit per stage.
// Depends on cpor_pkg for the unit widths; the quotient must fit DIV_Q_W bits.
module cpor_div
    import cpor_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_NUM_W-1:0] numer,
    input  logic [DIV_DEN_W-1:0] denom,
    output logic [DIV_Q_W-1:0]   quot
);

    logic [DIV_DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_Q_W-1:0]   lq_reg  [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_reg [DIV_STAGES];
    logic [DIV_DEN_W-1:0] rem_next [DIV_STAGES];
    logic [DIV_Q_W-1:0]   lq_next  [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_next [DIV_STAGES];

    // Low numerator bits shift out of lq while quotient bits shift in.
    always_comb
    begin
        logic [DIV_DEN_W-1:0] rem_cur;
        logic [DIV_Q_W-1:0]   lq_cur;
        logic [DIV_DEN_W-1:0] den_cur;
        logic [DIV_DEN_W:0]   rem_sh;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_cur = DIV_DEN_W'(numer[DIV_NUM_W-1:DIV_Q_W]);
                lq_cur  = numer[DIV_Q_W-1:0];
                den_cur = denom;
            end
            else
            begin
                rem_cur = rem_reg[k-1];
                lq_cur  = lq_reg[k-1];
                den_cur = den_reg[k-1];
            end
            rem_sh = {rem_cur, lq_cur[DIV_Q_W-1]};
            if (rem_sh >= {1'b0, den_cur})
            begin
                rem_next[k] = DIV_DEN_W'(rem_sh - {1'b0, den_cur});
                lq_next[k]  = {lq_cur[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh[DIV_DEN_W-1:0];
                lq_next[k]  = {lq_cur[DIV_Q_W-2:0], 1'b0};
            end
            den_next[k] = den_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rem_reg[k] <= rem_next[k];
            lq_reg[k]  <= lq_next[k];
            den_reg[k] <= den_next[k];
        end
    end

    assign quot = lq_reg[DIV_STAGES-1];

endmodule

### test/tb_circle_pair_overlap_resolver_unit.sv
// Self-checking testbench for circle_pair_overlap_resolver_unit: drives random and
// directed circle pairs, predicts the corrected positions and compares each result.
// Depends on cpor_pkg and the resolver RTL.
`timescale 1ns / 100ps

module tb_circle_pair_overlap_resolver_unit
    import cpor_pkg::*;
();

    localparam int LATENCY     = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [ID_W-1:0] ID_TOP = 16'hFFFF;
    localparam logic signed [POS_W-1:0] POS_TOP = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_BOT = -24'sh800000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    request_t         request;
    logic             done;
    result_t          result;
    logic             cfg_wr_en;
    logic [RAD_W-1:0] cfg_wr_data;

    logic [RAD_W-1:0] model_radius;
    result_t          pending_results[$];
    int               mismatch_count;
    int               result_count;
    int               request_count;
    int               cycle_count;
    int               push_count;
    int               normal_count;
    bit               idle_enabled;

    circle_pair_overlap_resolver_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input longint v);
        if (v > 64'sd8388607)
        begin
            return POS_TOP;
        end
        if (v < -64'sd8388608)
        begin
            return POS_BOT;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic longint push_component(input longint k, input longint unsigned n);
        longint unsigned ak;
        longint unsigned twice;
        longint q;
        ak = (k < 0) ? -k : k;
        twice = root_floor((4 * ak * ak * model_radius * model_radius) / (100 * n));
        q = (twice + 1) >> 1;
        return (k < 0) ? -q : q;
    endfunction

    function automatic result_t resolve_pair(input request_t req);
        result_t res;
        longint x1, y1, x2, y2, dx, dy, cx, cy, a, b;
        longint unsigned adx, ady, d2, dia, s, ov, den, n;
        x1 = req.first_x;
        y1 = req.first_y;
        x2 = req.second_x;
        y2 = req.second_y;
        dx = x1 - x2;
        dy = y1 - y2;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        d2 = adx * adx + ady * ady;
        dia = 2 * model_radius;
        res.resolution_kind = KIND_NONE;
        if (req.first_id != req.second_id && d2 < dia * dia)
        begin
            if (d2 > 65536 || d2 * 100000000 > 65536)
            begin
                s = root_floor(d2 << 16);
                ov = (dia << 8) - s;
                den = 4 * s;
                cx = (adx * ov + den / 2) / den;
                cy = (ady * ov + den / 2) / den;
                if (dx < 0)
                begin
                    cx = -cx;
                end
                if (dy < 0)
                begin
                    cy = -cy;
                end
                res.resolution_kind = KIND_NORMAL;
            end
            else
            begin
                a = longint'(req.first_id % 7) - 3;
                b = longint'(req.second_id % 5) - 2;
                if (a == 0 && b == 0)
                begin
                    a = 1;
                    b = 1;
                end
                n = a * a + b * b;
                cx = push_component(a, n);
                cy = push_component(b, n);
                res.resolution_kind = KIND_PUSH;
            end
            x1 += cx;
            y1 += cy;
            x2 -= cx;
            y2 -= cy;
        end
        res.new_first_x  = clamp_pos(x1);
        res.new_first_y  = clamp_pos(y1);
        res.new_second_x = clamp_pos(x2);
        res.new_second_y = clamp_pos(y2);
        return res;
    endfunction

    // Requests are accepted at the rising edge, so the prediction is queued there.
    always @(posedge clk)
    begin
        result_t expected;
        if (rst_n && start && !busy)
        begin
            pending_results = {pending_results, resolve_pair(request)};
            request_count = request_count + 1;
        end
        if (rst_n && done)
        begin
            result_count = result_count + 1;
            if (pending_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result %h", result);
                end
            end
            else
            begin
                expected = pending_results.pop_front();
                if (expected.resolution_kind == KIND_PUSH)
                begin
                    push_count = push_count + 1;
                end
                if (expected.resolution_kind == KIND_NORMAL)
                begin
                    normal_count = normal_count + 1;
                end
                if (result.new_first_x !== expected.new_first_x
                    || result.new_first_y !== expected.new_first_y
                    || result.new_second_x !== expected.new_second_x
                    || result.new_second_y !== expected.new_second_y
                    || result.resolution_kind !== expected.resolution_kind)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected %h %h %h %h k%0d, got %h %h %h %h k%0d",
                            expected.new_first_x, expected.new_first_y,
                            expected.new_second_x, expected.new_second_y,
                            expected.resolution_kind, result.new_first_x,
                            result.new_first_y, result.new_second_x,
                            result.new_second_y, result.resolution_kind);
                    end
                end
            end
        end
    end

    task automatic send_request(input request_t req);
        int gap;
        if (idle_enabled && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        model_radius = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic request_t make_pair(input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y, input int ox, input int oy,
        input logic [ID_W-1:0] id1, input logic [ID_W-1:0] id2);
        request_t req;
        req.first_x   = x;
        req.first_y   = y;
        req.second_x  = POS_W'(longint'(x) + ox);
        req.second_y  = POS_W'(longint'(y) + oy);
        req.first_id  = id1;
        req.second_id = id2;
        return req;
    endfunction

    task automatic test_directed_cases();
        request_t req;
        int i;
        send_request(make_pair(0, 0, 1000, 0, 5, 5));
        send_request(make_pair(0, 0, 1000, 300, 1, 2));
        send_request(make_pair(POS_TOP, POS_TOP, -100, -100, 7, 9));
        send_request(make_pair(POS_BOT, POS_BOT, 100, 100, 7, 9));
        send_request(make_pair(POS_TOP, POS_BOT, 0, 0, 0, 1));
        send_request(make_pair(POS_BOT, POS_TOP, 0, 0, ID_TOP, 0));
        send_request(make_pair(0, 0, 1, 0, 3, 2));
        send_request(make_pair(0, 0, 5120, 0, 3, 4));
        send_request(make_pair(0, 0, 5119, 0, 3, 4));
        send_request(make_pair(POS_TOP, POS_BOT, -1, 1, ID_TOP, ID_TOP - 16'd1));
        send_request(make_pair(POS_TOP, POS_TOP, POS_BOT, POS_BOT, 1, 2));
        // Twelve id residue pairs, including the one that falls back to the diagonal.
        for (i = 0; i < 12; i++)
        begin
            req = make_pair(POS_W'($urandom), POS_W'($urandom), 0, 0,
                16'(i * 3), 16'(i * 7 + 1));
            send_request(req);
        end
        send_request(make_pair(100, 100, 0, 0, 3, 2));
    endtask

    function automatic request_t random_pair();
        request_t req;
        int spread;
        req = request_t'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // Fully random fields.
            end
            2:
            begin
                req = make_pair(req.first_x, req.first_y, 0, 0,
                    req.first_id, req.second_id);
            end
            3:
            begin
                req.second_id = req.first_id;
                req = make_pair(req.first_x, req.first_y, $urandom_range(0, 400),
                    $urandom_range(0, 400), req.first_id, req.second_id);
            end
            default:
            begin
                spread = 4 * model_radius + 2;
                req = make_pair(req.first_x, req.first_y,
                    int'($urandom_range(0, spread)) - spread / 2,
                    int'($urandom_range(0, spread)) - spread / 2,
                    req.first_id, req.second_id);
            end
        endcase
        return req;
    endfunction

    task automatic test_random_pairs(input int count);
        repeat (count) send_request(random_pair());
    endtask

    task automatic test_radius_sweep();
        write_radius(16'd0);
        test_random_pairs(60);
        write_radius(16'hFFFF);
        test_random_pairs(120);
        write_radius(16'd1);
        test_random_pairs(60);
        write_radius(16'(($urandom_range(1, 4095))));
        test_random_pairs(150);
        write_radius(16'd2560);
        test_random_pairs(150);
    endtask

    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        test_random_pairs(280);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        model_radius   = RAD_RESET;
        mismatch_count = 0;
        result_count   = 0;
        request_count  = 0;
        cycle_count    = 0;
        push_count     = 0;
        normal_count   = 0;
        idle_enabled   = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_pairs(150);
        test_radius_sweep();
        test_back_to_back();
        drain_results();

        $display("Checked %0d results from %0d requests over five radius settings.",
            result_count, request_count);
        $display("Overlap corrections: %0d, coincident pushes: %0d, mismatches: %0d.",
            normal_count, push_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
